FILE: hw/rtl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and constants of the set membership table.
// ----------------------------------------------------------------------------
`default_nettype none

package smt_pkg;

  // store geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned FUNC_W   = 2;

  // output beat layout
  localparam int unsigned OUT_FIELD_W = 2 + CNT_W + 2 * VAL_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // empty-set reporting values
  localparam logic [VAL_W-1:0] EMPTY_MIN = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] EMPTY_MAX = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_REMOVE = 2'd2,
    FN_LOOKUP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // memory access from the scan engine
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // one result, last field in the lowest bits
  typedef struct packed {
    logic [VAL_W-1:0] maximum;
    logic [VAL_W-1:0] minimum;
    logic [CNT_W-1:0] count;
    logic             full_res;
    logic             found;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/smt_ram.sv
// ----------------------------------------------------------------------------
// smt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/smt_core.sv
// ----------------------------------------------------------------------------
// smt_core
// Scan engine: walks the stored entries once per item, finds the value,
// closes the gap on remove, appends on insert, and tracks minimum/maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_core
  import smt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // item side
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire func_e            in_func_i,
  input  wire logic [VAL_W-1:0] in_value_i,
  // store
  output mem_req_t              mem_o,
  input  wire logic [VAL_W-1:0] mem_rdata_i,
  // result side
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output res_t                  res_o
);

  state_e            state_q, state_d;
  func_e             func_q;
  logic [VAL_W-1:0]  value_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              p_vld_q, p_vld_d;
  logic [ADDR_W-1:0] p_idx_q, p_idx_d;
  logic              found_q, found_d;
  logic [VAL_W-1:0]  min_q, min_d;
  logic [VAL_W-1:0]  max_q, max_d;

  logic              accept;
  logic              issue;
  logic              hit;
  logic              keep;
  logic              shift_wr;
  logic              ins_ok;
  logic              ins_full;
  logic              finish;
  logic              scan_end;

  assign accept   = in_valid_i && in_ready_o;
  assign scan_end = (rd_idx_q == cnt_q) && !p_vld_q;
  assign finish   = res_valid_o && res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (scan_end) state_d = ST_DONE;
      ST_DONE: if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    issue       = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_SCAN: issue       = (rd_idx_q < cnt_q);
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // compare stage on the returning read beat
  assign hit      = p_vld_q && (mem_rdata_i == value_q);
  assign keep     = !((func_q == FN_REMOVE) && hit);
  // entries past the match move one place down
  assign shift_wr = p_vld_q && (func_q == FN_REMOVE) && found_q;

  assign ins_ok   = (func_q == FN_INSERT) && !found_q && (cnt_q != CNT_W'(CAPACITY));
  assign ins_full = (func_q == FN_INSERT) && !found_q && (cnt_q == CNT_W'(CAPACITY));

  // store access
  always_comb begin
    mem_o       = '0;
    mem_o.re    = issue;
    mem_o.raddr = rd_idx_q[ADDR_W-1:0];
    if (shift_wr) begin
      mem_o.we    = 1'b1;
      mem_o.waddr = p_idx_q - ADDR_W'(1);
      mem_o.wdata = mem_rdata_i;
    end else if (finish && ins_ok) begin
      mem_o.we    = 1'b1;
      mem_o.waddr = cnt_q[ADDR_W-1:0];
      mem_o.wdata = value_q;
    end
  end

  // scan bookkeeping and min/max accumulation
  always_comb begin
    rd_idx_d = rd_idx_q;
    p_vld_d  = issue;
    p_idx_d  = rd_idx_q[ADDR_W-1:0];
    found_d  = found_q;
    min_d    = min_q;
    max_d    = max_q;
    cnt_d    = cnt_q;
    if (accept) begin
      rd_idx_d = '0;
      found_d  = 1'b0;
      min_d    = EMPTY_MIN;
      max_d    = EMPTY_MAX;
    end
    if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end
    if (p_vld_q) begin
      found_d = found_q || hit;
      if (keep && ($signed(mem_rdata_i) < $signed(min_q))) min_d = mem_rdata_i;
      if (keep && ($signed(mem_rdata_i) > $signed(max_q))) max_d = mem_rdata_i;
    end
    if (finish) begin
      cnt_d = res_o.count;
    end
  end

  // result
  always_comb begin
    res_o.found    = found_q;
    res_o.full_res = ins_full;
    res_o.count    = cnt_q;
    res_o.minimum  = min_q;
    res_o.maximum  = max_q;
    priority if (func_q == FN_CLEAR) begin
      res_o.count   = '0;
      res_o.minimum = EMPTY_MIN;
      res_o.maximum = EMPTY_MAX;
    end else if (ins_ok) begin
      res_o.count   = cnt_q + CNT_W'(1);
      if ($signed(value_q) < $signed(min_q)) res_o.minimum = value_q;
      if ($signed(value_q) > $signed(max_q)) res_o.maximum = value_q;
    end else if ((func_q == FN_REMOVE) && found_q) begin
      res_o.count   = cnt_q - CNT_W'(1);
    end else begin
      res_o.count   = cnt_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      p_vld_q  <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      p_vld_q  <= p_vld_d;
      found_q  <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= in_func_i;
      value_q <= in_value_i;
    end
    p_idx_q <= p_idx_d;
    min_q   <= min_d;
    max_q   <= max_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/set_membership_table.sv
// ----------------------------------------------------------------------------
// set_membership_table
// Set of distinct signed 32-bit values with clear, insert, remove and lookup.
// ----------------------------------------------------------------------------
// Each beat on the slave side carries one operation (tuser) and one value
// (tdata) and yields exactly one result beat on the master side. The set
// lives in a 64-entry RAM with one read and one write port; every item walks
// the stored entries once, one per cycle through the read port. Removal
// closes the gap during that walk, keeping the order of the remaining
// entries. The result sits in an output register, so a new item can be taken
// while the previous result waits. No clearing pass is needed after reset.
`default_nettype none

module set_membership_table
  import smt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // slave side
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [VAL_W-1:0]      s_axis_tdata,   // value
  input  wire logic [FUNC_W-1:0]     s_axis_tuser,   // func
  // master side
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata    // found, full_res, count,
                                                     // minimum, maximum, zero pad
);

  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  smt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (func_e'(s_axis_tuser)),
    .in_value_i  (s_axis_tdata),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  smt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // output register, refilled as soon as it drains
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);

endmodule

`default_nettype wire

FILE: tb/sv/set_membership_table_tb.sv
// ----------------------------------------------------------------------------
// set_membership_table_tb
// Self-checking testbench for the set membership table.
// ----------------------------------------------------------------------------
// Each operation beat is mirrored by a small behavioral set inside the bench.
// The set is an ordered array plus a size. The expected result of every
// accepted beat is queued, and each result beat on the master side is checked
// field by field against the oldest entry. Directed tests cover the empty set,
// the extreme values, duplicates, absent removes and a completely filled
// store. A long random run then mixes grow, shrink and mixed phases. The
// sender idles in bursts and the receiver stalls on its own pattern.

module set_membership_table_tb
  import smt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // random phase kinds
  typedef enum int unsigned {
    PH_GROW,
    PH_SHRINK,
    PH_MIXED
  } phase_e;

  // receiver stall modes
  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [VAL_W-1:0]      s_axis_tdata  = '0;   // value
  logic [FUNC_W-1:0]     s_axis_tuser  = FN_LOOKUP;   // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // found, full_res, count, minimum, maximum

  // mirror of the set contents
  logic [VAL_W-1:0] set_elems [CAPACITY];
  int unsigned      set_size = 0;

  res_t        expected_results [$];
  int unsigned error_count = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_cnt   = 0;

  set_membership_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // position of a value in the mirror, -1 when absent
  function automatic int find_member(input logic [VAL_W-1:0] val);
    int pos;
    pos = -1;
    for (int i = 0; i < set_size; i++) begin
      if (set_elems[i] == val) begin
        pos = i;
        break;
      end
    end
    return pos;
  endfunction

  // apply one operation to the mirror and return the result it produces
  function automatic res_t apply_set_op(input func_e op, input logic [VAL_W-1:0] val);
    res_t             r;
    int               pos;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    pos        = find_member(val);
    r.found    = (pos >= 0);
    r.full_res = 1'b0;
    case (op)
      FN_CLEAR: begin
        set_size = 0;
      end
      FN_INSERT: begin
        if (pos < 0) begin
          if (set_size < CAPACITY) begin
            set_elems[set_size] = val;
            set_size++;
          end else begin
            r.full_res = 1'b1;
          end
        end
      end
      FN_REMOVE: begin
        // close the gap, keeping the order of the rest
        if (pos >= 0) begin
          for (int i = pos; i + 1 < set_size; i++) set_elems[i] = set_elems[i+1];
          set_size--;
        end
      end
      default: ;
    endcase
    lo = EMPTY_MIN;
    hi = EMPTY_MAX;
    for (int i = 0; i < set_size; i++) begin
      if ($signed(set_elems[i]) < $signed(lo)) lo = set_elems[i];
      if ($signed(set_elems[i]) > $signed(hi)) hi = set_elems[i];
    end
    r.count   = set_size[CNT_W-1:0];
    r.minimum = lo;
    r.maximum = hi;
    return r;
  endfunction

  // a value not currently in the set
  function automatic logic [VAL_W-1:0] fresh_value();
    logic [VAL_W-1:0] val;
    val = $urandom;
    while (find_member(val) >= 0) val = $urandom;
    return val;
  endfunction

  // corner values that random traffic keeps hitting
  function automatic logic [VAL_W-1:0] pool_value(input int unsigned idx);
    case (idx)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return 32'h7FFF_FFFE;
      6:       return 32'h8000_0001;
      7:       return 32'h5555_5555;
      8:       return 32'hAAAA_AAAA;
      9:       return 32'h0001_0000;
      10:      return 32'hFFFF_0000;
      default: return 32'h0000_002A;
    endcase
  endfunction

  // member, corner value or fully random value
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30 && set_size > 0) return set_elems[$urandom_range(0, set_size - 1)];
    if (sel < 55) return pool_value($urandom_range(0, 11));
    return $urandom;
  endfunction

  // send one beat, record its expected result, then maybe idle
  task automatic send_op(input func_e op, input logic [VAL_W-1:0] val);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(apply_set_op(op, val));
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // compare one field of a result beat
  task automatic check_field(input string name, input logic [VAL_W-1:0] exp_val,
                             input logic [VAL_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin : rx_side
    static rx_mode_e    rx_mode   = RX_OPEN;
    static int unsigned rx_left   = 0;
    static int unsigned rx_tick   = 0;
    res_t               got;
    res_t               want;
    logic               ready_next;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
      if (expected_results.size() == 0) begin
        $error("result beat with no expected result: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("found", want.found, got.found);
        check_field("full_res", want.full_res, got.full_res);
        check_field("count", want.count, got.count);
        check_field("minimum", want.minimum, got.minimum);
        check_field("maximum", want.maximum, got.maximum);
      end
    end
    // switch stall mode now and then
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     ready_next = 1'b1;
      RX_COIN:     ready_next = $urandom_range(0, 1);
      RX_SPARSE:   ready_next = ($urandom_range(0, 7) == 0);
      default:     ready_next = (rx_tick[2:0] != 3'd5) && (rx_tick[2:0] != 3'd6);
    endcase
    m_axis_tready <= ready_next;
  end

  // lookup, remove and clear on an empty set
  task automatic test_empty_set();
    send_op(FN_LOOKUP, 32'h0000_0000);
    send_op(FN_REMOVE, 32'h8000_0000);
    send_op(FN_CLEAR, 32'hFFFF_FFFF);
  endtask

  // extreme values, duplicates, absent removes and clear with a member
  task automatic test_extremes();
    send_op(FN_INSERT, 32'h8000_0000);
    send_op(FN_INSERT, 32'h7FFF_FFFF);
    send_op(FN_INSERT, 32'h0000_0000);
    send_op(FN_INSERT, 32'hFFFF_FFFF);
    send_op(FN_INSERT, 32'h7FFF_FFFF);
    send_op(FN_LOOKUP, 32'h8000_0000);
    send_op(FN_LOOKUP, 32'h1234_5678);
    send_op(FN_REMOVE, 32'h1234_5678);
    send_op(FN_REMOVE, 32'h7FFF_FFFF);
    send_op(FN_REMOVE, 32'h8000_0000);
    send_op(FN_REMOVE, 32'hFFFF_FFFF);
    send_op(FN_INSERT, 32'hAAAA_AAAA);
    send_op(FN_INSERT, 32'h5555_5555);
    send_op(FN_LOOKUP, 32'h0000_0000);
    send_op(FN_CLEAR, 32'h5555_5555);
    send_op(FN_LOOKUP, 32'h5555_5555);
    send_op(FN_INSERT, 32'h5555_5555);
    send_op(FN_CLEAR, 32'h0000_0001);
  endtask

  // fill the store, then refused insert, duplicate and reuse of a freed slot
  task automatic test_full_store();
    logic [VAL_W-1:0] val;
    for (int i = 0; i < CAPACITY; i++) send_op(FN_INSERT, fresh_value());
    send_op(FN_INSERT, fresh_value());
    send_op(FN_INSERT, set_elems[CAPACITY/2]);
    send_op(FN_LOOKUP, set_elems[CAPACITY-1]);
    val = set_elems[0];
    send_op(FN_REMOVE, val);
    send_op(FN_INSERT, fresh_value());
    send_op(FN_INSERT, val);
    send_op(FN_REMOVE, set_elems[CAPACITY-1]);
    send_op(FN_CLEAR, set_elems[3]);
  endtask

  // random operations in grow, shrink and mixed phases
  task automatic test_random_traffic();
    phase_e      phase;
    int unsigned phase_left;
    int unsigned sel;
    func_e       op;
    logic [VAL_W-1:0] val;
    phase      = PH_GROW;
    phase_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase      = phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(30, 90);
      end else begin
        phase_left--;
      end
      sel = $urandom_range(0, 99);
      case (phase)
        PH_GROW:   op = (sel < 75) ? FN_INSERT : (sel < 85) ? FN_REMOVE :
                        (sel < 98) ? FN_LOOKUP : FN_CLEAR;
        PH_SHRINK: op = (sel < 15) ? FN_INSERT : (sel < 80) ? FN_REMOVE :
                        (sel < 98) ? FN_LOOKUP : FN_CLEAR;
        default:   op = (sel < 35) ? FN_INSERT : (sel < 65) ? FN_REMOVE :
                        (sel < 97) ? FN_LOOKUP : FN_CLEAR;
      endcase
      // growing phases mostly bring new values so the store can fill up
      if (phase == PH_GROW && op == FN_INSERT && $urandom_range(0, 3) != 0)
        val = fresh_value();
      else if (phase == PH_SHRINK && op == FN_REMOVE && set_size > 0 &&
               $urandom_range(0, 3) != 0)
        val = set_elems[$urandom_range(0, set_size - 1)];
      else
        val = pick_value();
      send_op(op, val);
    end
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_set();
    test_extremes();
    test_full_store();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/smt_pkg.sv
hw/rtl/smt_ram.sv
hw/rtl/smt_core.sv
hw/rtl/set_membership_table.sv
tb/sv/set_membership_table_tb.sv
